// File: hdl/tccf_pkg.sv
// ----------------------------------------------------------------------------
// tccf_pkg
// shared widths, field offsets, register map and types of the coincidence finder
// ----------------------------------------------------------------------------
`default_nettype none

package tccf_pkg;

  localparam int TIME_BITS    = 32;
  localparam int CHANNEL_BITS = 6;
  localparam int ENERGY_BITS  = 15;
  localparam int FINE_BITS    = 5;
  localparam int COARSE_BITS  = 15;
  localparam int FRAME_BITS   = 16;
  localparam int WINDOW_BITS  = 10;
  localparam int DIFF_BITS    = 11;

  // input tdata layout, lowest bits first
  localparam int CH_LSB     = 0;
  localparam int TIME_LSB   = CH_LSB + CHANNEL_BITS;
  localparam int ENERGY_LSB = TIME_LSB + TIME_BITS;
  localparam int FINE_LSB   = ENERGY_LSB + ENERGY_BITS;
  localparam int ECM_LSB    = FINE_LSB + FINE_BITS;
  localparam int ECS_LSB    = ECM_LSB + COARSE_BITS;
  localparam int TCM_LSB    = ECS_LSB + COARSE_BITS;
  localparam int TCS_LSB    = TCM_LSB + COARSE_BITS;
  localparam int FRAME_LSB  = TCS_LSB + COARSE_BITS;
  localparam int HIT_BITS   = FRAME_LSB + FRAME_BITS;
  localparam int IN_TDATA_W = ((HIT_BITS + 7) / 8) * 8;

  localparam int RES_BITS    = DIFF_BITS + FRAME_BITS;
  localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_FIRST_CHANNEL  = 3'd0,
    REG_SECOND_CHANNEL = 3'd1,
    REG_TIME_WINDOW    = 3'd2,
    REG_FIRST_E_LOW    = 3'd3,
    REG_FIRST_E_HIGH   = 3'd4,
    REG_SECOND_E_LOW   = 3'd5,
    REG_SECOND_E_HIGH  = 3'd6,
    REG_UNUSED         = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] channel;
    logic [TIME_BITS-1:0]    hit_time;
    logic [ENERGY_BITS-1:0]  energy;
    logic [FINE_BITS-1:0]    fine;
    logic [COARSE_BITS-1:0]  ecm;
    logic [COARSE_BITS-1:0]  ecs;
    logic [COARSE_BITS-1:0]  tcm;
    logic [COARSE_BITS-1:0]  tcs;
    logic [FRAME_BITS-1:0]   frame;
    logic                    error;
  } hit_t;

  typedef struct packed {
    logic [DIFF_BITS-1:0]  diff;
    logic [FRAME_BITS-1:0] frame;
    logic                  last;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/two_channel_coincidence_finder_top.sv
// ----------------------------------------------------------------------------
// two_channel_coincidence_finder_top
// Filters detector hits, keeps the last accepted hit of two configured
// channels and emits the time difference of every coincident pair.
// ----------------------------------------------------------------------------
// One hit is taken per clock cycle unless the input stalls. A hit passes an
// input register and is evaluated from it against the stored hits of both
// channels once the result side can take it; its results land in a result
// register. A hit that pairs on both sides (both channel registers equal)
// yields two results and fills the result register and its spare slot, so
// evaluation then pauses while the spare result moves up. Backpressure on the
// result side stops evaluation; the input register still takes one more hit.
`default_nettype none

module two_channel_coincidence_finder_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // channel, time, energy, fine, ecm, ecs, tcm, tcs, frame, zero pad
  input  wire logic [tccf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // error flag
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // time difference, pair frame, zero pad
  output logic [tccf_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tccf_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [tccf_pkg::DATA_BITS-1:0]    pwdata,
  output logic [tccf_pkg::DATA_BITS-1:0]         prdata,
  output logic                                   pready
);

  import tccf_pkg::*;

  // configuration registers
  logic [CHANNEL_BITS-1:0] first_ch_r, second_ch_r;
  logic [WINDOW_BITS-1:0]  win_r;
  logic [ENERGY_BITS-1:0]  fel_r, feh_r, sel_r, seh_r;
  reg_idx_t                cfg_idx;
  logic                    cfg_wr;

  // input register
  logic s1_v_r;
  hit_t s1_r;

  // channel state
  logic [TIME_BITS-1:0]  first_time_r, second_time_r;
  logic [FRAME_BITS-1:0] first_frame_r, second_frame_r;
  logic                  first_seen_r, second_seen_r;

  // result register and spare slot
  logic out_v_r, spare_v_r;
  res_t out_r, spare_r;

  logic                  out_fire, proc;
  logic                  hit_ok, hit1, hit2, pair1, pair2;
  logic                  ecoarse_ok, tcoarse_ok;
  logic                  first_seen_u;
  logic [FRAME_BITS-1:0] first_frame_u;
  logic [TIME_BITS-1:0]  first_time_u;
  logic [TIME_BITS-1:0]  d1, d2, mag1, mag2;
  res_t                  res1, res2, r0, r1;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_FIRST_CHANNEL:  prdata = {{(DATA_BITS-CHANNEL_BITS){1'b0}}, first_ch_r};
      REG_SECOND_CHANNEL: prdata = {{(DATA_BITS-CHANNEL_BITS){1'b0}}, second_ch_r};
      REG_TIME_WINDOW:    prdata = {{(DATA_BITS-WINDOW_BITS){1'b0}}, win_r};
      REG_FIRST_E_LOW:    prdata = {{(DATA_BITS-ENERGY_BITS){1'b0}}, fel_r};
      REG_FIRST_E_HIGH:   prdata = {{(DATA_BITS-ENERGY_BITS){1'b0}}, feh_r};
      REG_SECOND_E_LOW:   prdata = {{(DATA_BITS-ENERGY_BITS){1'b0}}, sel_r};
      REG_SECOND_E_HIGH:  prdata = {{(DATA_BITS-ENERGY_BITS){1'b0}}, seh_r};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_ch_r  <= CHANNEL_BITS'(0);
      second_ch_r <= CHANNEL_BITS'(1);
      win_r       <= WINDOW_BITS'(70);
      fel_r       <= ENERGY_BITS'(130);
      feh_r       <= ENERGY_BITS'(170);
      sel_r       <= ENERGY_BITS'(130);
      seh_r       <= ENERGY_BITS'(170);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FIRST_CHANNEL:  first_ch_r  <= pwdata[CHANNEL_BITS-1:0];
        REG_SECOND_CHANNEL: second_ch_r <= pwdata[CHANNEL_BITS-1:0];
        REG_TIME_WINDOW:    win_r       <= pwdata[WINDOW_BITS-1:0];
        REG_FIRST_E_LOW:    fel_r       <= pwdata[ENERGY_BITS-1:0];
        REG_FIRST_E_HIGH:   feh_r       <= pwdata[ENERGY_BITS-1:0];
        REG_SECOND_E_LOW:   sel_r       <= pwdata[ENERGY_BITS-1:0];
        REG_SECOND_E_HIGH:  seh_r       <= pwdata[ENERGY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  assign out_fire  = out_v_r && out_tready;
  assign proc      = s1_v_r && !spare_v_r && (!out_v_r || out_fire);
  assign in_tready = !s1_v_r || proc;

  // hit screening
  assign ecoarse_ok = (s1_r.ecm == s1_r.ecs) ||
                      ({1'b0, s1_r.ecm} == ({1'b0, s1_r.ecs} + 1'b1));
  assign tcoarse_ok = (s1_r.tcm == s1_r.tcs) ||
                      ({1'b0, s1_r.tcm} == ({1'b0, s1_r.tcs} + 1'b1));
  assign hit_ok = (s1_r.hit_time != '0) && (s1_r.hit_time != '1) &&
                  ecoarse_ok && tcoarse_ok && !s1_r.error &&
                  (s1_r.energy != '0) && (s1_r.fine != '0);
  assign hit1 = hit_ok && (s1_r.channel == first_ch_r) &&
                (s1_r.energy > fel_r) && (s1_r.energy < feh_r);
  assign hit2 = hit_ok && (s1_r.channel == second_ch_r) &&
                (s1_r.energy > sel_r) && (s1_r.energy < seh_r);

  // first side pairs with the stored second hit
  assign d1    = s1_r.hit_time - second_time_r;
  assign mag1  = d1[TIME_BITS-1] ? (~d1 + 1'b1) : d1;
  assign pair1 = hit1 && second_seen_r && (s1_r.frame == second_frame_r) &&
                 (mag1 < {{(TIME_BITS-WINDOW_BITS){1'b0}}, win_r});

  // second side sees the first side already updated
  assign first_seen_u  = first_seen_r || hit1;
  assign first_frame_u = hit1 ? s1_r.frame : first_frame_r;
  assign first_time_u  = hit1 ? s1_r.hit_time : first_time_r;
  assign d2    = first_time_u - s1_r.hit_time;
  assign mag2  = d2[TIME_BITS-1] ? (~d2 + 1'b1) : d2;
  assign pair2 = hit2 && first_seen_u && (s1_r.frame == first_frame_u) &&
                 (mag2 < {{(TIME_BITS-WINDOW_BITS){1'b0}}, win_r});

  always_comb begin
    res1 = '{diff: d1[DIFF_BITS-1:0], frame: s1_r.frame, last: !pair2};
    res2 = '{diff: d2[DIFF_BITS-1:0], frame: s1_r.frame, last: 1'b1};
    r0   = pair1 ? res1 : res2;
    r1   = res2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      spare_v_r      <= 1'b0;
      first_seen_r   <= 1'b0;
      second_seen_r  <= 1'b0;
      first_time_r   <= '0;
      second_time_r  <= '0;
      first_frame_r  <= '0;
      second_frame_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_v_r <= 1'b1;
      end else if (proc) begin
        s1_v_r <= 1'b0;
      end
      if (proc) begin
        if (hit1) begin
          first_time_r  <= s1_r.hit_time;
          first_frame_r <= s1_r.frame;
          first_seen_r  <= 1'b1;
        end
        if (hit2) begin
          second_time_r  <= s1_r.hit_time;
          second_frame_r <= s1_r.frame;
          second_seen_r  <= 1'b1;
        end
        out_v_r   <= pair1 || pair2;
        spare_v_r <= pair1 && pair2;
      end else if (out_fire) begin
        out_v_r   <= spare_v_r;
        spare_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_r.channel  <= in_tdata[CH_LSB +: CHANNEL_BITS];
      s1_r.hit_time <= in_tdata[TIME_LSB +: TIME_BITS];
      s1_r.energy   <= in_tdata[ENERGY_LSB +: ENERGY_BITS];
      s1_r.fine     <= in_tdata[FINE_LSB +: FINE_BITS];
      s1_r.ecm      <= in_tdata[ECM_LSB +: COARSE_BITS];
      s1_r.ecs      <= in_tdata[ECS_LSB +: COARSE_BITS];
      s1_r.tcm      <= in_tdata[TCM_LSB +: COARSE_BITS];
      s1_r.tcs      <= in_tdata[TCS_LSB +: COARSE_BITS];
      s1_r.frame    <= in_tdata[FRAME_LSB +: FRAME_BITS];
      s1_r.error    <= in_tuser;
    end
    if (proc) begin
      out_r   <= r0;
      spare_r <= r1;
    end else if (out_fire) begin
      out_r <= spare_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {{(OUT_TDATA_W-RES_BITS){1'b0}}, out_r.frame, out_r.diff};

  // spare slot only ever backs a full result register
  a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> out_v_r)
    else $error("spare result without result register");

  // a double pairing leaves a non-final result followed by a final one
  a_double_pair: assert property (@(posedge clk) disable iff (!rst_n)
    proc && pair1 && pair2 |=> out_tvalid && !out_tlast && spare_v_r && spare_r.last)
    else $error("double pairing ordered wrongly");

  // a paired difference never reaches the most negative code
  a_diff_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_r.diff != {1'b1, {(DIFF_BITS-1){1'b0}}})
    else $error("time difference out of window range");

  // input stalls only while a hit waits in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_v_r && !proc)
    else $error("input stalled without a pending hit");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the two channel coincidence finder: hits are sent in
// bursts under random result backpressure, each accepted hit runs through a
// local coincidence predictor and every result is compared field by field.
// ----------------------------------------------------------------------------

module testbench;
  import tccf_pkg::*;

  localparam int SETTLE_CYCLES = 8;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tvalid = 1'b0;
  wire logic              in_tready;
  wire logic [OUT_TDATA_W-1:0] out_tdata;
  wire logic              out_tlast;
  wire logic              out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_BITS-1:0]   paddr = '0;
  logic [DATA_BITS-1:0]   pwdata = '0;
  wire logic [DATA_BITS-1:0] prdata;
  wire logic              pready;

  two_channel_coincidence_finder_top dut (
    .clk, .rst_n,
    .in_tdata, .in_tuser, .in_tvalid, .in_tready,
    .out_tdata, .out_tlast, .out_tvalid, .out_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copy
  logic [CHANNEL_BITS-1:0] cfg_first_ch  = 6'd0;
  logic [CHANNEL_BITS-1:0] cfg_second_ch = 6'd1;
  logic [WINDOW_BITS-1:0]  cfg_window    = 10'd70;
  logic [ENERGY_BITS-1:0]  cfg_first_lo  = 15'd130;
  logic [ENERGY_BITS-1:0]  cfg_first_hi  = 15'd170;
  logic [ENERGY_BITS-1:0]  cfg_second_lo = 15'd130;
  logic [ENERGY_BITS-1:0]  cfg_second_hi = 15'd170;

  // last stored hit per side
  logic [TIME_BITS-1:0]  first_time   = '0;
  logic [FRAME_BITS-1:0] first_frame  = '0;
  logic                  first_valid  = 1'b0;
  logic [TIME_BITS-1:0]  second_time  = '0;
  logic [FRAME_BITS-1:0] second_frame = '0;
  logic                  second_valid = 1'b0;

  hit_t hit_queue [$];
  res_t pair_queue [$];
  hit_t shown_hit;

  int hits_sent = 0;
  int hits_taken = 0;
  int pairs_checked = 0;
  int double_runs = 0;
  int settings_done = 0;
  int fail_count = 0;

  int burst_left = 0;
  int idle_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int mode_left = 0;

  logic [TIME_BITS-1:0]  track_time = 32'h0000_1000;
  logic [FRAME_BITS-1:0] track_frame = '0;

  function automatic bit coarse_ok(input logic [COARSE_BITS-1:0] m,
                                   input logic [COARSE_BITS-1:0] s);
    return m == s || {1'b0, m} == {1'b0, s} + 16'd1;
  endfunction

  // pairs the two stored hits, true when inside the window
  function automatic bit coincident(output res_t r);
    logic [TIME_BITS-1:0] d;
    logic [TIME_BITS-1:0] mag;
    d = first_time - second_time;
    mag = d[TIME_BITS-1] ? -d : d;
    r.diff = d[DIFF_BITS-1:0];
    r.frame = first_frame;
    r.last = 1'b0;
    return mag < {22'd0, cfg_window};
  endfunction

  function automatic void predict_pairs(input hit_t h);
    res_t got [2];
    int n;
    n = 0;
    if (h.hit_time == '0 || h.hit_time == '1 || h.error || h.energy == '0 || h.fine == '0)
      return;
    if (!coarse_ok(h.ecm, h.ecs) || !coarse_ok(h.tcm, h.tcs))
      return;
    if (h.channel == cfg_first_ch && h.energy > cfg_first_lo && h.energy < cfg_first_hi) begin
      first_time = h.hit_time;
      first_frame = h.frame;
      first_valid = 1'b1;
      if (second_valid && h.frame == second_frame && coincident(got[n]))
        n++;
    end
    if (h.channel == cfg_second_ch && h.energy > cfg_second_lo && h.energy < cfg_second_hi) begin
      second_time = h.hit_time;
      second_frame = h.frame;
      second_valid = 1'b1;
      if (first_valid && h.frame == first_frame && coincident(got[n]))
        n++;
    end
    if (n == 2)
      double_runs++;
    for (int i = 0; i < n; i++) begin
      got[i].last = (i == n - 1);
      pair_queue.push_back(got[i]);
    end
  endfunction

  function automatic hit_t good_hit(input logic [CHANNEL_BITS-1:0] ch,
                                    input logic [TIME_BITS-1:0] t,
                                    input logic [ENERGY_BITS-1:0] e,
                                    input logic [FRAME_BITS-1:0] fr);
    hit_t h;
    h.channel = ch;
    h.hit_time = t;
    h.energy = e;
    h.fine = 5'($urandom_range(1, 31));
    h.ecs = 15'($urandom);
    h.ecm = (h.ecs == '1) ? h.ecs : h.ecs + 15'($urandom_range(0, 1));
    h.tcs = 15'($urandom);
    h.tcm = (h.tcs == '1) ? h.tcs : h.tcs + 15'($urandom_range(0, 1));
    h.frame = fr;
    h.error = 1'b0;
    return h;
  endfunction

  function automatic logic [ENERGY_BITS-1:0] energy_in(input logic [ENERGY_BITS-1:0] lo,
                                                       input logic [ENERGY_BITS-1:0] hi);
    if (int'(hi) > int'(lo) + 1)
      return 15'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return 15'($urandom);
  endfunction

  // mostly plausible hits near the running time and frame, some noise
  function automatic hit_t random_hit();
    hit_t h;
    int pick;
    int off;
    logic [CHANNEL_BITS-1:0] ch;
    logic [ENERGY_BITS-1:0] e;
    logic [FRAME_BITS-1:0] fr;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      track_frame = 16'($urandom);
    else if (pick < 12)
      track_frame = track_frame + 16'd1;
    if ($urandom_range(0, 49) == 0)
      track_time = $urandom;
    else
      track_time = track_time + 32'($urandom_range(0, 300));
    off = int'($urandom_range(0, 2 * int'(cfg_window) + 40)) - int'(cfg_window) - 20;
    case ($urandom_range(0, 4))
      0, 1: ch = cfg_first_ch;
      2, 3: ch = cfg_second_ch;
      default: ch = 6'($urandom);
    endcase
    if ($urandom_range(0, 4) == 0)
      e = 15'($urandom);
    else if (ch == cfg_first_ch && (ch != cfg_second_ch || $urandom_range(0, 1) == 0))
      e = energy_in(cfg_first_lo, cfg_first_hi);
    else
      e = energy_in(cfg_second_lo, cfg_second_hi);
    fr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : track_frame;
    h = good_hit(ch, track_time + 32'(off), e, fr);
    if (pick >= 86) begin
      case ($urandom_range(0, 7))
        0: h.hit_time = '0;
        1: h.hit_time = '1;
        2: h.error = 1'b1;
        3: h.energy = '0;
        4: h.fine = '0;
        5: h.ecm = h.ecs + 15'($urandom_range(2, 32767));
        6: h.tcm = h.tcs + 15'($urandom_range(2, 32767));
        default: begin
          h.channel = 6'($urandom);
          h.hit_time = $urandom;
          h.energy = 15'($urandom);
          h.fine = 5'($urandom);
          h.ecm = 15'($urandom);
          h.ecs = 15'($urandom);
          h.tcm = 15'($urandom);
          h.tcs = 15'($urandom);
          h.frame = 16'($urandom);
          h.error = 1'($urandom);
        end
      endcase
    end
    return h;
  endfunction

  task automatic queue_hit(input hit_t h);
    hit_queue.push_back(h);
    hits_sent++;
  endtask

  // all hits taken, all results back, then let the pipeline empty
  task automatic drain();
    while (hits_taken != hits_sent || pair_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_BITS-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FIRST_CHANNEL:  cfg_first_ch  = value[CHANNEL_BITS-1:0];
      REG_SECOND_CHANNEL: cfg_second_ch = value[CHANNEL_BITS-1:0];
      REG_TIME_WINDOW:    cfg_window    = value[WINDOW_BITS-1:0];
      REG_FIRST_E_LOW:    cfg_first_lo  = value[ENERGY_BITS-1:0];
      REG_FIRST_E_HIGH:   cfg_first_hi  = value[ENERGY_BITS-1:0];
      REG_SECOND_E_LOW:   cfg_second_lo = value[ENERGY_BITS-1:0];
      REG_SECOND_E_HIGH:  cfg_second_hi = value[ENERGY_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int a, input int b, input int w,
                               input int flo, input int fhi, input int slo, input int shi);
    write_reg(REG_FIRST_CHANNEL, 32'(a));
    write_reg(REG_SECOND_CHANNEL, 32'(b));
    write_reg(REG_TIME_WINDOW, 32'(w));
    write_reg(REG_FIRST_E_LOW, 32'(flo));
    write_reg(REG_FIRST_E_HIGH, 32'(fhi));
    write_reg(REG_SECOND_E_LOW, 32'(slo));
    write_reg(REG_SECOND_E_HIGH, 32'(shi));
    settings_done++;
  endtask

  // hit driver and input side prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_pairs(shown_hit);
        hits_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (idle_left > 0 || hit_queue.size() == 0) begin
          if (idle_left > 0)
            idle_left--;
          in_tvalid <= 1'b0;
        end else begin
          shown_hit = hit_queue.pop_front();
          in_tdata <= IN_TDATA_W'({shown_hit.frame, shown_hit.tcs, shown_hit.tcm,
                                   shown_hit.ecs, shown_hit.ecm, shown_hit.fine,
                                   shown_hit.energy, shown_hit.hit_time, shown_hit.channel});
          in_tuser <= shown_hit.error;
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 3) == 0)
              idle_left = $urandom_range(8, 30);
            else
              idle_left = $urandom_range(0, 4);
          end
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pair_queue.size() == 0) begin
          $error("unexpected transaction: time_difference %0d pair_frame %0h",
                 $signed(out_tdata[DIFF_BITS-1:0]), out_tdata[DIFF_BITS +: FRAME_BITS]);
          fail_count++;
        end else begin
          res_t want;
          want = pair_queue.pop_front();
          pairs_checked++;
          if (out_tdata[DIFF_BITS-1:0] !== want.diff) begin
            $error("time_difference: expected %0d, actual %0d",
                   $signed(want.diff), $signed(out_tdata[DIFF_BITS-1:0]));
            fail_count++;
          end
          if (out_tdata[DIFF_BITS +: FRAME_BITS] !== want.frame) begin
            $error("pair_frame: expected %0h, actual %0h",
                   want.frame, out_tdata[DIFF_BITS +: FRAME_BITS]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
        default:   out_tready <= (mode_left % 5 != 0);
      endcase
    end
  end

  initial begin
    #3_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    hit_t h;
    int a;
    int b;
    int lo;
    int hi;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: channels 0 and 1, window 70, energies 130..170
    queue_hit(good_hit(6'd0, 32'd1000, 15'd150, 16'd5));
    queue_hit(good_hit(6'd1, 32'd1030, 15'd150, 16'd5));
    queue_hit(good_hit(6'd1, 32'd1069, 15'd169, 16'd5));
    queue_hit(good_hit(6'd1, 32'd1070, 15'd131, 16'd5));
    queue_hit(good_hit(6'd0, 32'd1001, 15'd150, 16'd6));
    queue_hit(good_hit(6'd1, 32'd1001, 15'd130, 16'd6));
    queue_hit(good_hit(6'd1, 32'd1001, 15'd170, 16'd6));
    queue_hit(good_hit(6'd1, 32'd0, 15'd150, 16'd6));
    queue_hit(good_hit(6'd1, '1, 15'd150, 16'd6));
    h = good_hit(6'd1, 32'd1002, 15'd150, 16'd6);
    h.error = 1'b1;
    queue_hit(h);
    h = good_hit(6'd1, 32'd1002, 15'd150, 16'd6);
    h.ecm = h.ecs + 15'd2;
    queue_hit(h);
    h = good_hit(6'd1, 32'd1002, 15'd150, 16'd6);
    h.tcs = 15'd100;
    h.tcm = 15'd99;
    queue_hit(h);
    h = good_hit(6'd1, 32'd1002, 15'd150, 16'd6);
    h.ecs = '1;
    h.ecm = '0;
    queue_hit(h);
    h = good_hit(6'd1, 32'd1010, 15'd150, 16'd6);
    h.ecs = '1;
    h.ecm = '1;
    h.tcs = '1;
    h.tcm = '1;
    queue_hit(h);
    queue_hit(good_hit(6'd0, 32'hFFFF_FFFE, 15'd150, 16'd7));
    queue_hit(good_hit(6'd1, 32'd5, 15'd150, 16'd7));
    h = good_hit(6'd63, 32'd7, 15'h7FFF, 16'hFFFF);
    h.fine = 5'd31;
    queue_hit(h);
    drain();

    // both sides on one channel, full window and energy range
    apply_setting(63, 63, 1023, 0, 32767, 0, 32767);
    queue_hit(good_hit(6'd63, 32'd5000, 15'h7FFE, 16'hFFFF));
    queue_hit(good_hit(6'd63, 32'd6000, 15'd1, 16'hFFFF));
    h = good_hit(6'd63, 32'd6100, 15'd100, 16'hFFFF);
    h.fine = '0;
    queue_hit(h);
    h = good_hit(6'd63, 32'd6100, 15'd100, 16'hFFFF);
    h.energy = '0;
    queue_hit(h);
    drain();

    // most negative difference and the window edges
    apply_setting(5, 40, 1023, 0, 32767, 0, 32767);
    queue_hit(good_hit(6'd5, 32'h8000_0001, 15'd200, 16'd9));
    queue_hit(good_hit(6'd40, 32'd1, 15'd200, 16'd9));
    queue_hit(good_hit(6'd40, 32'h8000_0001 - 32'd1022, 15'd200, 16'd9));
    queue_hit(good_hit(6'd40, 32'h8000_0001 + 32'd1022, 15'd200, 16'd9));
    queue_hit(good_hit(6'd40, 32'h8000_0001 - 32'd1023, 15'd200, 16'd9));
    drain();

    for (int p = 0; p < 6; p++) begin
      a = $urandom_range(0, 63);
      b = (a + $urandom_range(1, 63)) % 64;
      lo = $urandom_range(0, 32000);
      hi = lo + $urandom_range(2, 700);
      case (p)
        0: apply_setting(a, b, $urandom_range(1, 1023), lo, hi, lo, hi);
        1: apply_setting(a, a, $urandom_range(1, 1023), lo, hi, $urandom_range(0, 300), 32767);
        2: apply_setting(a, b, 0, lo, hi, lo, hi);
        3: apply_setting(a, b, $urandom_range(1, 1023), hi, hi, lo, hi);
        4: apply_setting(0, 63, 1023, 0, 32767, 0, 32767);
        default: apply_setting(b, a, 1, lo, hi, lo + 1, lo);
      endcase
      for (int i = 0; i < 170; i++)
        queue_hit(random_hit());
      drain();
    end

    $display("run covered %0d hits over %0d register settings", hits_taken, settings_done);
    $display("%0d coincidences checked, %0d hits paired on both sides", pairs_checked,
             double_runs);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
